// ----- rtl/zero_run_length_decoder_macros.svh -----
// Assertion helpers for the zero run-length decoder.
`ifndef ZERO_RUN_LENGTH_DECODER_MACROS_SVH
`define ZERO_RUN_LENGTH_DECODER_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(label, expr, msg)
`define ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ----- rtl/zrld_pkg.sv -----
package zrld_pkg;

  localparam int LEN_BITS       = 32;
  localparam int VAR_DIGIT      = 7;
  localparam int VAR_MAX_BYTES  = 7;
  localparam int VAR_BITS       = VAR_DIGIT * VAR_MAX_BYTES;
  localparam int VAR_SHIFT_BITS = $clog2(VAR_BITS);
  localparam int VAR_CNT_BITS   = $clog2(VAR_MAX_BYTES + 1);
  localparam int WIDE_BITS      = VAR_BITS + 1;
  localparam int KIND_BITS      = 2;
  localparam int STATUS_BITS    = 2;
  localparam int CFG_IDX_BITS   = 8;

  localparam logic [3:0] NIBBLE_EXT = 4'hF;

  localparam logic [CFG_IDX_BITS-1:0] REG_IN_LENGTH    = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_OUT_CAPACITY = CFG_IDX_BITS'(1);

  typedef enum logic [KIND_BITS-1:0] {
    KIND_LITERAL = 2'd0,
    KIND_ZERO    = 2'd1,
    KIND_STATUS  = 2'd2
  } kind_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK      = 2'd0,
    ST_CORRUPT = 2'd1,
    ST_SPACE   = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    PH_TOKEN  = 4'b0001,
    PH_LITVAR = 4'b0010,
    PH_LIT    = 4'b0100,
    PH_ZVAR   = 4'b1000
  } phase_t;

endpackage

// ----- rtl/zrld_if.sv -----
interface zrld_byte_if import zrld_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface zrld_res_if import zrld_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [KIND_BITS-1:0]   kind;
  logic [7:0]             value;
  logic [LEN_BITS-1:0]    run_length;
  logic                   done_res;
  logic [STATUS_BITS-1:0] status;
  logic [LEN_BITS-1:0]    total_out;

  modport source (output valid, output kind, output value, output run_length,
                  output done_res, output status, output total_out, input ready);
  modport sink (input valid, input kind, input value, input run_length,
                input done_res, input status, input total_out, output ready);
endinterface

interface zrld_cfg_if import zrld_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [CFG_IDX_BITS-1:0] index;
  logic [LEN_BITS-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/zero_run_length_decoder.sv -----
// Zero run-length decoder.
// din carries one compressed byte per beat. dout carries one result per beat:
// a literal byte (with the frame's zero run attached to the last literal when
// the count sat in the token), a zero run, or a status-only final beat.
// cfg writes in_length (index 0) or out_capacity (index 1); either write
// restarts the stream. cfg is always ready; write it only while idle.
// A byte is registered on acceptance and decoded into the result register
// when that register advances; a result passes through the byte register
// and then the result register before its beat.
// Throughput is one byte per cycle; the byte register and the result register
// both advance whenever the result register is empty or being taken.
// Bytes that produce no result leave no beat. When the result register is
// stalled, one more byte may be held; din.ready then drops.
// The final result carries done_res and the status; later bytes are taken
// and dropped until cfg is written again.
// Reset empties both registers and clears the lengths and the stream state.
`include "zero_run_length_decoder_macros.svh"

module zero_run_length_decoder import zrld_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  zrld_byte_if.sink din,
  zrld_res_if.source dout,
  zrld_cfg_if.sink  cfg
);

  logic [LEN_BITS-1:0]     in_length;
  logic [LEN_BITS-1:0]     out_capacity;
  phase_t                  phase;
  logic [3:0]              zero_nibble;
  logic [LEN_BITS-1:0]     literals_left;
  logic [VAR_BITS-1:0]     varint_value;
  logic [VAR_CNT_BITS-1:0] varint_bytes;
  logic [LEN_BITS-1:0]     rem_in;
  logic [LEN_BITS-1:0]     rem_cap;
  logic [LEN_BITS-1:0]     produced;
  logic                    stopped;

  logic       held;
  logic [7:0] held_byte;

  logic                   res_valid;
  kind_t                  res_kind;
  logic [7:0]             res_value;
  logic [LEN_BITS-1:0]    res_run;
  logic                   res_done;
  status_t                res_status;
  logic [LEN_BITS-1:0]    res_total;

  logic adv, take, active, res_load, cfg_we, cfg_hit;
  logic [LEN_BITS-1:0] new_len, new_cap;

  phase_t                  phase_next;
  logic [3:0]              zero_nibble_next;
  logic [LEN_BITS-1:0]     literals_left_next;
  logic [VAR_BITS-1:0]     varint_value_next;
  logic [VAR_CNT_BITS-1:0] varint_bytes_next;
  logic [LEN_BITS-1:0]     rem_cap_next;
  logic [LEN_BITS-1:0]     produced_next;

  kind_t               kind_c;
  status_t             err_c;
  logic [LEN_BITS-1:0] run_c;
  logic [7:0]          value_c;
  logic                have_c, done_c;
  logic                do_begin, do_after, do_zero;
  logic [WIDE_BITS-1:0] lit_len, zero_len;
  logic [LEN_BITS-1:0] in_cur, cap_cur;
  logic [VAR_BITS-1:0] vv_or;
  logic [VAR_SHIFT_BITS-1:0] vv_shift;

  assign adv      = !res_valid || dout.ready;
  assign take     = held && adv;
  assign active   = !stopped && (rem_in != '0);
  assign res_load = take && active && have_c;
  assign din.ready = !held || adv;

  assign cfg.ready = 1'b1;
  assign cfg_we  = cfg.valid;
  assign cfg_hit = cfg_we && (cfg.index inside {REG_IN_LENGTH, REG_OUT_CAPACITY});
  assign new_len = (cfg.index == REG_IN_LENGTH) ? cfg.data : in_length;
  assign new_cap = (cfg.index == REG_OUT_CAPACITY) ? cfg.data : out_capacity;

  assign vv_shift = VAR_SHIFT_BITS'(VAR_DIGIT * int'(varint_bytes));
  assign vv_or    = varint_value | (VAR_BITS'(held_byte[6:0]) << vv_shift);
  assign in_cur   = rem_in - LEN_BITS'(1);

  always_comb begin
    kind_c             = KIND_STATUS;
    err_c              = ST_OK;
    run_c              = '0;
    value_c            = '0;
    have_c             = 1'b0;
    do_begin           = 1'b0;
    do_after           = 1'b0;
    do_zero            = 1'b0;
    lit_len            = '0;
    zero_len           = '0;
    cap_cur            = rem_cap;
    phase_next         = phase;
    zero_nibble_next   = zero_nibble;
    literals_left_next = literals_left;
    varint_value_next  = varint_value;
    varint_bytes_next  = varint_bytes;
    produced_next      = produced;

    case (phase)
      PH_TOKEN: begin
        if (held_byte == 8'h00) begin
          err_c = ST_CORRUPT;
        end else begin
          zero_nibble_next = held_byte[3:0];
          if (held_byte[7:4] == NIBBLE_EXT) begin
            phase_next        = PH_LITVAR;
            varint_value_next = '0;
            varint_bytes_next = '0;
          end else begin
            do_begin = 1'b1;
            lit_len  = WIDE_BITS'(held_byte[7:4]);
          end
        end
      end
      PH_LIT: begin
        kind_c             = KIND_LITERAL;
        value_c            = held_byte;
        have_c             = 1'b1;
        produced_next      = produced + LEN_BITS'(1);
        cap_cur            = rem_cap - LEN_BITS'(1);
        literals_left_next = literals_left - LEN_BITS'(1);
        do_after           = (literals_left_next == '0);
      end
      PH_LITVAR, PH_ZVAR: begin
        varint_value_next = vv_or;
        if (held_byte[7]) begin
          varint_bytes_next = varint_bytes + VAR_CNT_BITS'(1);
          if (varint_bytes_next == VAR_CNT_BITS'(VAR_MAX_BYTES)) err_c = ST_CORRUPT;
        end else if (phase == PH_LITVAR) begin
          do_begin = 1'b1;
          lit_len  = WIDE_BITS'(NIBBLE_EXT) + WIDE_BITS'(vv_or);
        end else begin
          do_zero  = 1'b1;
          zero_len = WIDE_BITS'(NIBBLE_EXT) + WIDE_BITS'(vv_or);
        end
      end
      default: begin
        err_c = ST_CORRUPT;
      end
    endcase

    if (do_begin) begin
      if (lit_len > WIDE_BITS'(in_cur)) begin
        err_c = ST_CORRUPT;
      end else if (lit_len > WIDE_BITS'(cap_cur)) begin
        err_c = ST_SPACE;
      end else if (lit_len != '0) begin
        literals_left_next = lit_len[LEN_BITS-1:0];
        phase_next         = PH_LIT;
      end else begin
        do_after = 1'b1;
      end
    end

    if (do_after) begin
      if (zero_nibble_next == NIBBLE_EXT) begin
        phase_next        = PH_ZVAR;
        varint_value_next = '0;
        varint_bytes_next = '0;
      end else begin
        do_zero  = 1'b1;
        zero_len = WIDE_BITS'(zero_nibble_next);
      end
    end

    rem_cap_next = cap_cur;
    if (do_zero) begin
      if (zero_len > WIDE_BITS'(cap_cur)) begin
        err_c = ST_SPACE;
      end else begin
        produced_next = produced_next + zero_len[LEN_BITS-1:0];
        rem_cap_next  = cap_cur - zero_len[LEN_BITS-1:0];
        run_c         = zero_len[LEN_BITS-1:0];
        if (!have_c) kind_c = KIND_ZERO;
        have_c     = 1'b1;
        phase_next = PH_TOKEN;
      end
    end

    if (err_c == ST_OK && rem_in == LEN_BITS'(1) && phase_next != PH_TOKEN) begin
      err_c = ST_CORRUPT;
    end
    done_c = (err_c != ST_OK) || (rem_in == LEN_BITS'(1));
    if (done_c) begin
      have_c = 1'b1;
      if (err_c != ST_OK && kind_c == KIND_ZERO) begin
        kind_c = KIND_STATUS;
        run_c  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (din.ready) begin
      held <= din.valid;
    end
    if (din.valid && din.ready) held_byte <= din.in_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_length     <= '0;
      out_capacity  <= '0;
      phase         <= PH_TOKEN;
      zero_nibble   <= '0;
      literals_left <= '0;
      varint_value  <= '0;
      varint_bytes  <= '0;
      rem_in        <= '0;
      rem_cap       <= '0;
      produced      <= '0;
      stopped       <= 1'b0;
    end else if (cfg_hit) begin
      in_length     <= new_len;
      out_capacity  <= new_cap;
      phase         <= PH_TOKEN;
      zero_nibble   <= '0;
      literals_left <= '0;
      varint_value  <= '0;
      varint_bytes  <= '0;
      rem_in        <= new_len;
      rem_cap       <= new_cap;
      produced      <= '0;
      stopped       <= 1'b0;
    end else if (take && active) begin
      phase         <= phase_next;
      zero_nibble   <= zero_nibble_next;
      literals_left <= literals_left_next;
      varint_value  <= varint_value_next;
      varint_bytes  <= varint_bytes_next;
      rem_in        <= in_cur;
      rem_cap       <= rem_cap_next;
      produced      <= produced_next;
      stopped       <= done_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= res_load;
    end
    if (res_load) begin
      res_kind   <= kind_c;
      res_value  <= value_c;
      res_run    <= run_c;
      res_done   <= done_c;
      res_status <= done_c ? err_c : ST_OK;
      res_total  <= produced_next;
    end
  end

  assign dout.valid      = res_valid;
  assign dout.kind       = res_kind;
  assign dout.value      = res_value;
  assign dout.run_length = res_run;
  assign dout.done_res   = res_done;
  assign dout.status     = res_status;
  assign dout.total_out  = res_total;

  `ASSERT_ALWAYS(a_cap_sum, LEN_BITS'(produced + rem_cap) == out_capacity, "capacity split lost")
  `ASSERT_ALWAYS(a_varint_len, stopped || (phase != PH_LITVAR && phase != PH_ZVAR) || varint_bytes < VAR_CNT_BITS'(VAR_MAX_BYTES), "varint count overrun")
  `ASSERT_ALWAYS(a_lit_left, stopped || phase != PH_LIT || literals_left != '0, "literal phase with no literals")
  `ASSERT_NEXT(a_total, res_load && !cfg_hit, res_total == produced, "total out of step")

endmodule
